/* hdl/hsv_to_rgb_pixel_writer_defines.svh */
// Assertion macros for the HSV to RGB pixel writer.
// Used inside modules that declare clk and arst_n; no other dependencies.
`ifndef HSV_TO_RGB_PIXEL_WRITER_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_WRITER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define HSVPW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define HSVPW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hsvpw_pkg.sv */
// Shared widths, constants and types of the HSV to RGB pixel writer.
// No dependencies; imported by the channel interfaces and the top level.
package hsvpw_pkg;

	localparam int unsigned IdxW   = 10;
	localparam int unsigned HueW   = 16;
	localparam int unsigned UnitW  = 17;
	localparam int unsigned ChanW  = 8;
	localparam int unsigned CountW = 11;

	localparam logic [CountW-1:0] LedCountReset  = 11'd256;
	localparam int unsigned       MaxLedsDefault = 1024;
	localparam logic [UnitW-1:0]  OneQ16         = 17'h10000;

	// Hue sector of the six-sector scheme
	typedef enum logic [2:0] {
		SECT_RED_YEL = 3'd0,
		SECT_YEL_GRN = 3'd1,
		SECT_GRN_CYN = 3'd2,
		SECT_CYN_BLU = 3'd3,
		SECT_BLU_MAG = 3'd4,
		SECT_MAG_RED = 3'd5
	} sector_t;

	// Limit a Q1.16 value to 1.0
	function automatic logic [UnitW-1:0] clamp_one(input logic [UnitW-1:0] x);
		clamp_one = (x > OneQ16) ? OneQ16 : x;
	endfunction

endpackage

/* hdl/hsvpw_hsv_if.sv */
// Input channel of the pixel writer: LED index and HSV colour.
// Depends on hsvpw_pkg for field widths.
interface hsvpw_hsv_if
	import hsvpw_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [IdxW-1:0]  led_index;
	logic [HueW-1:0]  hue;
	logic [UnitW-1:0] saturation;
	logic [UnitW-1:0] brightness;

	modport source (output valid, led_index, hue, saturation, brightness, input ready);
	modport sink   (input valid, led_index, hue, saturation, brightness, output ready);
endinterface

/* hdl/hsvpw_pixel_if.sv */
// Output channel of the pixel writer: LED index and RGB bytes.
// Depends on hsvpw_pkg for field widths.
interface hsvpw_pixel_if
	import hsvpw_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [IdxW-1:0]  pixel_index;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;

	modport source (output valid, pixel_index, red, green, blue, input ready);
	modport sink   (input valid, pixel_index, red, green, blue, output ready);
endinterface

/* hdl/hsv_to_rgb_pixel_writer.sv */
// HSV to RGB pixel writer, six-sector scheme, four-stage pipeline.
// Depends on hsvpw_pkg, hsvpw_hsv_if, hsvpw_pixel_if and the defines header.
//
// Usage:
//   hsv   : input items (led_index, hue, saturation, brightness), valid/ready.
//   pixel : result items (pixel_index, red, green, blue), valid/ready.
//   cfg_we/cfg_wdata : write the LED count; change it only while idle.
// An item whose index is at or above min(led count, MAX_LEDS) is dropped
// at the input and yields no result. Saturation and brightness above 1.0
// are clamped. Channels are exact products truncated toward zero.
// A kept item passes through stages 1, 2 and 3 into the stage 4 register, which drives pixel.
// Throughput: one item per cycle while pixel is not stalled; the four register
// stages are hue sector, the products, the q and t multiplies and channel select.
// A stall on pixel fills empty stages first; hsv.ready drops only when
// every stage holds an item. Nothing is lost or repeated under stalls.
// Reset empties all stages and sets the LED count to 256.
`include "hsv_to_rgb_pixel_writer_defines.svh"

module hsv_to_rgb_pixel_writer
	import hsvpw_pkg::*;
#(
	parameter int unsigned MAX_LEDS = MaxLedsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata,
	hsvpw_hsv_if.sink         hsv,
	hsvpw_pixel_if.source     pixel
);

	logic [CountW-1:0] led_count_q;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	logic             adv1, adv2, adv3, adv4;
	logic             keep_c;

	// stage 1: sector, fraction, clamped saturation, scaled value
	logic [IdxW-1:0]  idx_s1;
	sector_t          sector_s1;
	logic [15:0]      f_s1;
	logic [UnitW-1:0] s_s1;
	logic [23:0]      vq_s1;

	// stage 2: products of fraction and saturation, v and p
	logic [IdxW-1:0]  idx_s2;
	sector_t          sector_s2;
	logic [23:0]      vq_s2;
	logic [ChanW-1:0] v_s2, p_s2;
	logic [31:0]      fs_s2;
	logic [32:0]      ft_s2;

	// stage 3: q and t
	logic [IdxW-1:0]  idx_s3;
	sector_t          sector_s3;
	logic [ChanW-1:0] v_s3, p_s3, q_s3, t_s3;

	// stage 4: output register
	logic [IdxW-1:0]  idx_s4;
	logic [ChanW-1:0] red_s4, green_s4, blue_s4;

	logic [18:0]      h6_c;
	logic [UnitW-1:0] bri_c;
	logic [24:0]      vq_c;
	logic [40:0]      pprod_c;
	logic [33:0]      ftprod_c;
	logic [32:0]      qm_c, tm_c;
	logic [56:0]      qprod_c, tprod_c;

	// hold the LED count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= LedCountReset;
		end else if (cfg_we) begin
			led_count_q <= cfg_wdata;
		end
	end

	// advance a stage when it is empty or its successor advances
	assign adv4 = !valid_s4 || pixel.ready;
	assign adv3 = !valid_s3 || adv4;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign hsv.ready = adv1;

	// drop items beyond the chain
	assign keep_c = ({1'b0, hsv.led_index} < led_count_q)
		&& (32'(hsv.led_index) < MAX_LEDS);

	assign h6_c  = 19'(hsv.hue) * 19'd6;
	assign bri_c = clamp_one(hsv.brightness);
	assign vq_c  = {bri_c, 8'd0} - 25'(bri_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= hsv.valid && keep_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			idx_s1    <= hsv.led_index;
			sector_s1 <= sector_t'(h6_c[18:16]);
			f_s1      <= h6_c[15:0];
			s_s1      <= clamp_one(hsv.saturation);
			vq_s1     <= vq_c[23:0];
		end
	end

	// stage 2 products
	assign pprod_c  = 41'(vq_s1) * 41'(OneQ16 - s_s1);
	assign ftprod_c = 34'(OneQ16 - {1'b0, f_s1}) * 34'(s_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			idx_s2    <= idx_s1;
			sector_s2 <= sector_s1;
			vq_s2     <= vq_s1;
			v_s2      <= vq_s1[23:16];
			p_s2      <= pprod_c[39:32];
			fs_s2     <= 32'(33'(f_s1) * 33'(s_s1));
			ft_s2     <= ftprod_c[32:0];
		end
	end

	// stage 3: scale the value by the complemented products
	assign qm_c    = 33'h1_0000_0000 - {1'b0, fs_s2};
	assign tm_c    = 33'h1_0000_0000 - ft_s2;
	assign qprod_c = 57'(vq_s2) * 57'(qm_c);
	assign tprod_c = 57'(vq_s2) * 57'(tm_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			idx_s3    <= idx_s2;
			sector_s3 <= sector_s2;
			v_s3      <= v_s2;
			p_s3      <= p_s2;
			q_s3      <= qprod_c[55:48];
			t_s3      <= tprod_c[55:48];
		end
	end

	// stage 4: route v, p, q, t to the channels by sector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			idx_s4 <= idx_s3;
			case (sector_s3)
				SECT_RED_YEL: begin
					red_s4 <= v_s3; green_s4 <= t_s3; blue_s4 <= p_s3;
				end
				SECT_YEL_GRN: begin
					red_s4 <= q_s3; green_s4 <= v_s3; blue_s4 <= p_s3;
				end
				SECT_GRN_CYN: begin
					red_s4 <= p_s3; green_s4 <= v_s3; blue_s4 <= t_s3;
				end
				SECT_CYN_BLU: begin
					red_s4 <= p_s3; green_s4 <= q_s3; blue_s4 <= v_s3;
				end
				SECT_BLU_MAG: begin
					red_s4 <= t_s3; green_s4 <= p_s3; blue_s4 <= v_s3;
				end
				default: begin
					red_s4 <= v_s3; green_s4 <= p_s3; blue_s4 <= q_s3;
				end
			endcase
		end
	end

	assign pixel.valid       = valid_s4;
	assign pixel.pixel_index = idx_s4;
	assign pixel.red         = red_s4;
	assign pixel.green       = green_s4;
	assign pixel.blue        = blue_s4;

	// an accepted item enters stage 1 exactly when its index is in range
	`HSVPW_ASSERT_NEXT(a_keep_on_accept, hsv.valid && hsv.ready,
		valid_s1 == $past(keep_c), "stage 1 valid does not match index check")
	// an item in stage 2 that advances lands in stage 3
	`HSVPW_ASSERT_NEXT(a_s2_moves, valid_s2 && adv3, valid_s3,
		"item lost between stage 2 and stage 3")
	// a stalled stage 3 keeps its results
	`HSVPW_ASSERT_NEXT(a_s3_holds, valid_s3 && !adv4,
		valid_s3 && $stable(q_s3) && $stable(t_s3) && $stable(idx_s3),
		"stage 3 changed while stalled")
	// with the back two stages full and stalled, input waits only on stages 1 and 2
	`HSVPW_ASSERT_SAME(a_ready_fill, valid_s3 && valid_s4 && !pixel.ready,
		hsv.ready == (!valid_s1 || !valid_s2), "input ready wrong under output stall")

endmodule
